// ----- hdl/sadll_pkg.sv -----
`timescale 1ns / 1ps

package sadll_pkg;

    // Width of the operation code and of the status code.
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 3;

    // Operation requested by one input transaction. Code 7 is a no-op.
    typedef enum logic [KIND_W-1:0] {
        KIND_ADD_FIRST = 3'd0,
        KIND_ADD_AFTER = 3'd1,
        KIND_ADD_LAST  = 3'd2,
        KIND_DEL_FIRST = 3'd3,
        KIND_DEL_AFTER = 3'd4,
        KIND_DEL_LAST  = 3'd5,
        KIND_READ_SLOT = 3'd6
    } t_kind;

    // Outcome reported with every result transaction.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_NO_POS  = 3'd3,
        ST_NO_SUCC = 3'd4
    } t_status;

endpackage

// ----- hdl/sadll_ram.sv -----
`timescale 1ns / 1ps

module sadll_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/slot_array_doubly_linked_list_core.sv -----
`timescale 1ns / 1ps

// Doubly linked list held in a fixed array of SLOTS slots. Each input transaction asks
// for one operation (add first, add after a slot, add last, delete first, delete after
// a slot, delete last, read a slot, or a no-op for the unused code) and produces exactly
// one result transaction carrying the status, the slot touched, and the count, head and
// tail after the operation. New records always land in the lowest numbered free slot.
// The block sustains one transaction per clock cycle unless the result side stalls. A
// request is held in the input register, where the whole list update is computed in a
// single pass over the used marks and link registers (the free-slot priority encoder
// and the neighbor link rewrite set that path). Its result is then loaded into the
// result register, from which the receiver takes it. Records live in a RAM with
// registered read, addressed directly from i_position at acceptance, so no clearing
// pass is needed after reset; the list is empty and ready as soon as reset is released.
module slot_array_doubly_linked_list_core #(
    parameter int SLOTS       = 16,
    parameter int RECORD_BITS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Request channel.
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [sadll_pkg::KIND_W-1:0]       i_kind,
    input  logic [$clog2(SLOTS)-1:0]           i_position,
    input  logic [RECORD_BITS-1:0]             i_record,
    // Result channel.
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [sadll_pkg::STATUS_W-1:0]     o_status,
    output logic [$clog2(SLOTS+1)-1:0]         o_slot,
    output logic [$clog2(SLOTS+1)-1:0]         o_count,
    output logic [$clog2(SLOTS+1)-1:0]         o_head_out,
    output logic [$clog2(SLOTS+1)-1:0]         o_tail_out,
    output logic [RECORD_BITS-1:0]             o_record_out,
    output logic [$clog2(SLOTS+1)-1:0]         o_prev_out,
    output logic [$clog2(SLOTS+1)-1:0]         o_next_out
);

    // IDX_W addresses a slot; LINK_W also holds the value SLOTS, which marks "none".
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int LINK_W = $clog2(SLOTS + 1);
    localparam logic [LINK_W-1:0] NONE = LINK_W'(SLOTS);

    // Handshake control.
    logic r_s1_valid;
    logic r_out_valid;
    logic s1_adv;
    logic in_accept;

    // Input register.
    sadll_pkg::t_kind        r_kind;
    logic [IDX_W-1:0]        r_pos;
    logic [RECORD_BITS-1:0]  r_rec;

    // List state. The used marks reset; the links are only read for used slots.
    logic [SLOTS-1:0]        r_used;
    logic [LINK_W-1:0]       r_prev [SLOTS];
    logic [LINK_W-1:0]       r_next [SLOTS];
    logic [LINK_W-1:0]       r_head;
    logic [LINK_W-1:0]       r_tail;
    logic [LINK_W-1:0]       r_count;

    logic [SLOTS-1:0]        n_used;
    logic [LINK_W-1:0]       n_prev [SLOTS];
    logic [LINK_W-1:0]       n_next [SLOTS];
    logic [LINK_W-1:0]       n_head;
    logic [LINK_W-1:0]       n_tail;
    logic [LINK_W-1:0]       n_count;

    // Record RAM and the forwarding register that covers a read of a slot written by
    // the transaction just ahead of it.
    logic                    ram_we;
    logic [RECORD_BITS-1:0]  ram_rdata;
    logic                    r_fwd_valid;
    logic [RECORD_BITS-1:0]  r_fwd_data;
    logic [RECORD_BITS-1:0]  rd_rec;

    // Single-pass decode and update.
    logic [LINK_W-1:0]       free_slot;
    logic [LINK_W-1:0]       pos_link;
    logic                    pos_in;
    logic                    full;
    logic                    do_ins;
    logic                    do_del;
    logic [LINK_W-1:0]       ins_anchor;
    logic [LINK_W-1:0]       ins_next;
    logic [LINK_W-1:0]       del_target;
    logic [LINK_W-1:0]       del_prev;
    logic [LINK_W-1:0]       del_next;

    sadll_pkg::t_status      res_status;
    logic [LINK_W-1:0]       res_slot;
    logic [RECORD_BITS-1:0]  res_rec;
    logic [LINK_W-1:0]       res_prev;
    logic [LINK_W-1:0]       res_next;

    // Result register.
    sadll_pkg::t_status      r_status;
    logic [LINK_W-1:0]       r_slot;
    logic [LINK_W-1:0]       r_cnt_out;
    logic [LINK_W-1:0]       r_head_out;
    logic [LINK_W-1:0]       r_tail_out;
    logic [RECORD_BITS-1:0]  r_rec_out;
    logic [LINK_W-1:0]       r_prev_out;
    logic [LINK_W-1:0]       r_next_out;

    // The input register moves on whenever the result register is empty or being drained.
    assign s1_adv    = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_s1_valid && !s1_adv;
    assign in_accept = i_valid && !o_stall;

    // Lowest free slot: the last assignment in the descending scan wins.
    always_comb begin
        free_slot = NONE;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_slot = LINK_W'(i);
            end
        end
    end

    // A position at or beyond SLOTS is never part of the list.
    assign pos_link = LINK_W'(r_pos);
    assign pos_in   = (pos_link < NONE) && r_used[r_pos];
    assign full     = (r_count >= NONE);
    assign rd_rec   = r_fwd_valid ? r_fwd_data : ram_rdata;

    always_comb begin
        n_used     = r_used;
        n_prev     = r_prev;
        n_next     = r_next;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        res_status = sadll_pkg::ST_OK;
        res_slot   = NONE;
        res_rec    = '0;
        res_prev   = NONE;
        res_next   = NONE;
        do_ins     = 1'b0;
        do_del     = 1'b0;
        ins_anchor = NONE;
        ins_next   = NONE;
        del_target = NONE;
        del_prev   = NONE;
        del_next   = NONE;
        ram_we     = 1'b0;

        unique case (r_kind)
            sadll_pkg::KIND_ADD_FIRST, sadll_pkg::KIND_ADD_LAST: begin
                if (full) begin
                    res_status = sadll_pkg::ST_FULL;
                end else begin
                    // Adding last to an empty list anchors on "none", i.e. adds first.
                    do_ins     = 1'b1;
                    ins_anchor = (r_kind == sadll_pkg::KIND_ADD_FIRST) ? NONE : r_tail;
                end
            end
            sadll_pkg::KIND_ADD_AFTER: begin
                if (full) begin
                    res_status = sadll_pkg::ST_FULL;
                end else if (!pos_in) begin
                    res_status = sadll_pkg::ST_NO_POS;
                end else begin
                    do_ins     = 1'b1;
                    ins_anchor = pos_link;
                end
            end
            sadll_pkg::KIND_DEL_FIRST, sadll_pkg::KIND_DEL_LAST: begin
                if (r_head == NONE) begin
                    res_status = sadll_pkg::ST_EMPTY;
                end else begin
                    do_del     = 1'b1;
                    del_target = (r_kind == sadll_pkg::KIND_DEL_FIRST) ? r_head : r_tail;
                end
            end
            sadll_pkg::KIND_DEL_AFTER: begin
                if (!pos_in) begin
                    res_status = sadll_pkg::ST_NO_POS;
                end else if (r_next[r_pos] == NONE) begin
                    res_status = sadll_pkg::ST_NO_SUCC;
                end else begin
                    do_del     = 1'b1;
                    del_target = r_next[r_pos];
                end
            end
            sadll_pkg::KIND_READ_SLOT: begin
                if (!pos_in) begin
                    res_status = sadll_pkg::ST_NO_POS;
                end else begin
                    res_slot = pos_link;
                    res_rec  = rd_rec;
                    res_prev = r_prev[r_pos];
                    res_next = r_next[r_pos];
                end
            end
            default: begin
            end
        endcase

        if (do_ins) begin
            ins_next = (ins_anchor == NONE) ? r_head : r_next[ins_anchor[IDX_W-1:0]];
            res_slot = free_slot;
            ram_we   = 1'b1;
            n_used[free_slot[IDX_W-1:0]] = 1'b1;
            n_prev[free_slot[IDX_W-1:0]] = ins_anchor;
            n_next[free_slot[IDX_W-1:0]] = ins_next;
            if (ins_anchor == NONE) begin
                n_head = free_slot;
            end else begin
                n_next[ins_anchor[IDX_W-1:0]] = free_slot;
            end
            if (ins_next != NONE) begin
                n_prev[ins_next[IDX_W-1:0]] = free_slot;
            end else begin
                n_tail = free_slot;
            end
            n_count = r_count + LINK_W'(1);
        end

        if (do_del) begin
            del_prev = r_prev[del_target[IDX_W-1:0]];
            del_next = r_next[del_target[IDX_W-1:0]];
            res_slot = del_target;
            if (del_prev != NONE) begin
                n_next[del_prev[IDX_W-1:0]] = del_next;
            end else begin
                n_head = del_next;
            end
            if (del_next != NONE) begin
                n_prev[del_next[IDX_W-1:0]] = del_prev;
            end else begin
                n_tail = del_prev;
            end
            n_used[del_target[IDX_W-1:0]] = 1'b0;
            if (r_count != '0) begin
                n_count = r_count - LINK_W'(1);
            end
        end
    end

    sadll_ram #(
        .WIDTH (RECORD_BITS),
        .DEPTH (SLOTS)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (s1_adv && ram_we),
        .i_waddr (free_slot[IDX_W-1:0]),
        .i_wdata (r_rec),
        .i_re    (in_accept),
        .i_raddr (i_position),
        .o_rdata (ram_rdata)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_used      <= '0;
            r_head      <= NONE;
            r_tail      <= NONE;
            r_count     <= '0;
        end else begin
            if (!o_stall) begin
                r_s1_valid <= i_valid;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (in_accept) begin
                // The RAM returns the old word when the slot is written on the same edge.
                r_fwd_valid <= s1_adv && ram_we && (free_slot == LINK_W'(i_position));
            end
            if (s1_adv) begin
                r_used  <= n_used;
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
        end
    end

    // Payload registers, links and results.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind     <= sadll_pkg::t_kind'(i_kind);
            r_pos      <= i_position;
            r_rec      <= i_record;
            r_fwd_data <= r_rec;
        end
        if (s1_adv) begin
            r_prev     <= n_prev;
            r_next     <= n_next;
            r_status   <= res_status;
            r_slot     <= res_slot;
            r_cnt_out  <= n_count;
            r_head_out <= n_head;
            r_tail_out <= n_tail;
            r_rec_out  <= res_rec;
            r_prev_out <= res_prev;
            r_next_out <= res_next;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_slot       = r_slot;
    assign o_count      = r_cnt_out;
    assign o_head_out   = r_head_out;
    assign o_tail_out   = r_tail_out;
    assign o_record_out = r_rec_out;
    assign o_prev_out   = r_prev_out;
    assign o_next_out   = r_next_out;

    // The element count never exceeds the number of slots.
    a_count_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NONE)
        else $error("element count beyond slot count");

    // An empty list has neither head nor tail, and a non-empty one has both.
    a_head_tail_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_head == NONE) == (r_count == '0)) && ((r_tail == NONE) == (r_count == '0)))
        else $error("head, tail and count disagree");

    // The head always names a used slot.
    a_head_used : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head != NONE) |-> r_used[r_head[IDX_W-1:0]])
        else $error("head points at a free slot");

    // A successful add grows the list by exactly one element.
    a_add_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && do_ins) |=> (r_count == $past(r_count) + LINK_W'(1)))
        else $error("add did not grow the count by one");

endmodule

// ----- tb/slot_array_doubly_linked_list_core_tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the slot array doubly linked list core.
module slot_array_doubly_linked_list_core_tb;

    localparam int SLOTS       = 16;
    localparam int RECORD_BITS = 64;
    localparam int POS_W       = 4;
    localparam int LINK_W      = 5;
    localparam int RAND_ITEMS  = 800;
    localparam int MAX_GAP     = 19;
    localparam int DRAIN_WAIT  = 10;

    // A link value of SLOTS stands for "no slot".
    localparam logic [LINK_W-1:0] NONE = LINK_W'(SLOTS);

    // The package has no member for the unused code, which the block treats as a no-op.
    localparam logic [sadll_pkg::KIND_W-1:0] KIND_NOP = 3'd7;

    // One result transaction, field by field, at the widths of the ports.
    typedef struct packed {
        logic [sadll_pkg::STATUS_W-1:0] status;
        logic [LINK_W-1:0]              slot;
        logic [LINK_W-1:0]              count;
        logic [LINK_W-1:0]              head;
        logic [LINK_W-1:0]              tail;
        logic [RECORD_BITS-1:0]         record;
        logic [LINK_W-1:0]              prev_link;
        logic [LINK_W-1:0]              next_link;
    } t_list_result;

    // The random part runs in phases. Growing phases push the list to full and beyond,
    // shrinking phases drain it to empty and beyond, and mixed phases throw in every code.
    typedef enum int {
        PH_GROW,
        PH_SHRINK,
        PH_MIXED
    } t_phase;

    // Shadow copy of the list. Every accepted request transaction is applied to it, and
    // the result that the block must return for it is queued in order.
    class t_list_shadow;
        bit                     used[SLOTS];
        logic [LINK_W-1:0]      prev_of[SLOTS];
        logic [LINK_W-1:0]      next_of[SLOTS];
        logic [RECORD_BITS-1:0] rec_of[SLOTS];
        logic [LINK_W-1:0]      head;
        logic [LINK_W-1:0]      tail;
        logic [LINK_W-1:0]      count;
        t_list_result           due_results[$];

        function new();
            foreach (used[i]) begin
                used[i]    = 1'b0;
                prev_of[i] = NONE;
                next_of[i] = NONE;
                rec_of[i]  = '0;
            end
            head  = NONE;
            tail  = NONE;
            count = '0;
        endfunction

        // Places a record in the lowest free slot right after anchor, or at the head
        // when anchor is NONE. Returns the slot taken.
        function logic [LINK_W-1:0] link_in(logic [LINK_W-1:0] anchor,
                                            logic [RECORD_BITS-1:0] rec);
            logic [LINK_W-1:0] s;
            logic [LINK_W-1:0] nx;
            s = NONE;
            for (int i = SLOTS - 1; i >= 0; i--) begin
                if (!used[i]) s = LINK_W'(i);
            end
            if (s == NONE) return NONE;
            used[s[POS_W-1:0]]   = 1'b1;
            rec_of[s[POS_W-1:0]] = rec;
            nx = (anchor == NONE) ? head : next_of[anchor[POS_W-1:0]];
            prev_of[s[POS_W-1:0]] = anchor;
            next_of[s[POS_W-1:0]] = nx;
            if (anchor == NONE) head = s;
            else next_of[anchor[POS_W-1:0]] = s;
            if (nx != NONE) prev_of[nx[POS_W-1:0]] = s;
            else tail = s;
            count++;
            return s;
        endfunction

        // Takes a used slot out of the chain and frees it.
        function void unlink(logic [LINK_W-1:0] s);
            logic [LINK_W-1:0] pv;
            logic [LINK_W-1:0] nx;
            pv = prev_of[s[POS_W-1:0]];
            nx = next_of[s[POS_W-1:0]];
            if (pv != NONE) next_of[pv[POS_W-1:0]] = nx;
            else head = nx;
            if (nx != NONE) prev_of[nx[POS_W-1:0]] = pv;
            else tail = pv;
            used[s[POS_W-1:0]] = 1'b0;
            if (count != 0) count--;
        endfunction

        // Applies one accepted request and queues the result it must produce.
        function void note_request(logic [sadll_pkg::KIND_W-1:0] kind,
                                   logic [POS_W-1:0] pos,
                                   logic [RECORD_BITS-1:0] rec);
            t_list_result r;
            r.status    = sadll_pkg::ST_OK;
            r.slot      = NONE;
            r.record    = '0;
            r.prev_link = NONE;
            r.next_link = NONE;
            case (kind)
                sadll_pkg::KIND_ADD_FIRST, sadll_pkg::KIND_ADD_LAST: begin
                    if (count >= SLOTS) begin
                        r.status = sadll_pkg::ST_FULL;
                    end else begin
                        r.slot = link_in((kind == sadll_pkg::KIND_ADD_FIRST) ? NONE : tail,
                                         rec);
                    end
                end
                sadll_pkg::KIND_ADD_AFTER: begin
                    // Fullness wins over a bad position.
                    if (count >= SLOTS) r.status = sadll_pkg::ST_FULL;
                    else if (!used[pos]) r.status = sadll_pkg::ST_NO_POS;
                    else r.slot = link_in(LINK_W'(pos), rec);
                end
                sadll_pkg::KIND_DEL_FIRST, sadll_pkg::KIND_DEL_LAST: begin
                    if (head == NONE) begin
                        r.status = sadll_pkg::ST_EMPTY;
                    end else begin
                        r.slot = (kind == sadll_pkg::KIND_DEL_FIRST) ? head : tail;
                        unlink(r.slot);
                    end
                end
                sadll_pkg::KIND_DEL_AFTER: begin
                    if (!used[pos]) begin
                        r.status = sadll_pkg::ST_NO_POS;
                    end else if (next_of[pos] == NONE) begin
                        r.status = sadll_pkg::ST_NO_SUCC;
                    end else begin
                        r.slot = next_of[pos];
                        unlink(r.slot);
                    end
                end
                sadll_pkg::KIND_READ_SLOT: begin
                    if (!used[pos]) begin
                        r.status = sadll_pkg::ST_NO_POS;
                    end else begin
                        r.slot      = LINK_W'(pos);
                        r.record    = rec_of[pos];
                        r.prev_link = prev_of[pos];
                        r.next_link = next_of[pos];
                    end
                end
                default: begin
                end
            endcase
            r.count = count;
            r.head  = head;
            r.tail  = tail;
            due_results.push_back(r);
        endfunction

        // Compares one result with the oldest queued one. On a mismatch, why lists
        // every field that differs as seen/wanted.
        function bit check_result(t_list_result seen, output string why);
            t_list_result want;
            why = "";
            if (due_results.size() == 0) begin
                why = $sformatf(" result %h arrived with nothing pending", seen);
                return 1'b0;
            end
            want = due_results.pop_front();
            if (seen.status !== want.status)
                why = {why, $sformatf(" status %0d/%0d", seen.status, want.status)};
            if (seen.slot !== want.slot)
                why = {why, $sformatf(" slot %0d/%0d", seen.slot, want.slot)};
            if (seen.count !== want.count)
                why = {why, $sformatf(" count %0d/%0d", seen.count, want.count)};
            if (seen.head !== want.head)
                why = {why, $sformatf(" head %0d/%0d", seen.head, want.head)};
            if (seen.tail !== want.tail)
                why = {why, $sformatf(" tail %0d/%0d", seen.tail, want.tail)};
            if (seen.record !== want.record)
                why = {why, $sformatf(" record %h/%h", seen.record, want.record)};
            if (seen.prev_link !== want.prev_link)
                why = {why, $sformatf(" prev %0d/%0d", seen.prev_link, want.prev_link)};
            if (seen.next_link !== want.next_link)
                why = {why, $sformatf(" next %0d/%0d", seen.next_link, want.next_link)};
            return why == "";
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    logic [sadll_pkg::KIND_W-1:0]   i_kind;
    logic [POS_W-1:0]               i_position;
    logic [RECORD_BITS-1:0]         i_record;
    logic                           o_valid;
    logic                           i_stall;
    logic [sadll_pkg::STATUS_W-1:0] o_status;
    logic [LINK_W-1:0]              o_slot;
    logic [LINK_W-1:0]              o_count;
    logic [LINK_W-1:0]              o_head_out;
    logic [LINK_W-1:0]              o_tail_out;
    logic [RECORD_BITS-1:0]         o_record_out;
    logic [LINK_W-1:0]              o_prev_out;
    logic [LINK_W-1:0]              o_next_out;

    t_list_shadow shadow;
    int unsigned  mismatch_count = 0;
    // While set, neither side idles, so back-to-back transactions are exercised.
    bit           quiet_phase = 1'b0;

    slot_array_doubly_linked_list_core #(
        .SLOTS       (SLOTS),
        .RECORD_BITS (RECORD_BITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_position   (i_position),
        .i_record     (i_record),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_slot       (o_slot),
        .o_count      (o_count),
        .o_head_out   (o_head_out),
        .o_tail_out   (o_tail_out),
        .o_record_out (o_record_out),
        .o_prev_out   (o_prev_out),
        .o_next_out   (o_next_out)
    );

    // 8 ns clock period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(string why);
        mismatch_count++;
        $display("%0t ns mismatch:%s", $time, why);
    endtask

    // Idle cycles that a side inserts ahead of its next transaction.
    function automatic int unsigned draw_gap();
        if (quiet_phase) return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Sends one request transaction. This is called at a rising edge and returns at the
    // edge where the block took the transaction. Valid stays high on return, so a
    // following call with no gap keeps the channel busy on consecutive cycles, and only
    // one assignment to i_valid happens in any time step.
    task automatic send_op(logic [sadll_pkg::KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                           logic [RECORD_BITS-1:0] rec);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_kind     <= kind;
        i_position <= pos;
        i_record   <= rec;
        // The values seen here are the ones from before this edge's updates, which is
        // exactly what the block samples at the same edge.
        do @(posedge i_clk); while (o_stall !== 1'b0);
        shadow.note_request(kind, pos, rec);
    endtask

    // Growing phases mostly add and shrinking phases mostly delete. A slice of every
    // phase, and all of a mixed phase, draws any 3-bit code, the no-op included.
    function automatic logic [sadll_pkg::KIND_W-1:0] pick_kind(t_phase ph);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (ph == PH_MIXED || roll >= 85) return sadll_pkg::KIND_W'($urandom_range(0, 7));
        if (ph == PH_GROW) begin
            case (roll % 3)
                0:       return sadll_pkg::KIND_ADD_FIRST;
                1:       return sadll_pkg::KIND_ADD_AFTER;
                default: return sadll_pkg::KIND_ADD_LAST;
            endcase
        end
        case (roll % 3)
            0:       return sadll_pkg::KIND_DEL_FIRST;
            1:       return sadll_pkg::KIND_DEL_AFTER;
            default: return sadll_pkg::KIND_DEL_LAST;
        endcase
    endfunction

    // Result side. The receiver stalls for a random number of cycles before each result
    // and then takes the first one that shows up.
    initial begin
        t_list_result seen;
        string        why;
        int unsigned  gap;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = draw_gap();
            if (gap != 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            seen.status    = o_status;
            seen.slot      = o_slot;
            seen.count     = o_count;
            seen.head      = o_head_out;
            seen.tail      = o_tail_out;
            seen.record    = o_record_out;
            seen.prev_link = o_prev_out;
            seen.next_link = o_next_out;
            if (!shadow.check_result(seen, why)) report_mismatch(why);
        end
    end

    // Stimulus and end of run.
    initial begin
        t_phase                       ph;
        int unsigned                  sent;
        int unsigned                  phase_len;
        logic [sadll_pkg::KIND_W-1:0] kind;
        logic [POS_W-1:0]             pos;
        logic [RECORD_BITS-1:0]       rec;
        int unsigned                  roll;

        shadow     = new();
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_kind     <= KIND_NOP;
        i_position <= '0;
        i_record   <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. On the empty list, every operation that needs an element must
        // fail with the proper status, and the no-op must leave everything alone.
        send_op(sadll_pkg::KIND_READ_SLOT, 4'd0, '0);
        send_op(sadll_pkg::KIND_DEL_FIRST, 4'd0, '0);
        send_op(sadll_pkg::KIND_DEL_LAST, 4'd0, '0);
        send_op(sadll_pkg::KIND_DEL_AFTER, 4'd0, '0);
        send_op(sadll_pkg::KIND_ADD_AFTER, 4'd0, '1);
        send_op(KIND_NOP, 4'd15, '1);
        // Add last on an empty list acts as add first and takes slot 0. Then build the
        // chain 1, 3, 0, 2: insertion at the head, after the tail and in the middle.
        send_op(sadll_pkg::KIND_ADD_LAST, 4'd0, '1);
        send_op(sadll_pkg::KIND_ADD_FIRST, 4'd0, '0);
        send_op(sadll_pkg::KIND_ADD_AFTER, 4'd0, {RECORD_BITS/8{8'hA5}});
        send_op(sadll_pkg::KIND_ADD_AFTER, 4'd1, {RECORD_BITS/8{8'h5A}});
        send_op(sadll_pkg::KIND_READ_SLOT, 4'd3, '0);
        send_op(sadll_pkg::KIND_READ_SLOT, 4'd2, '0);
        send_op(sadll_pkg::KIND_READ_SLOT, 4'd15, '0);
        // Delete after the tail has no successor to remove.
        send_op(sadll_pkg::KIND_DEL_AFTER, 4'd2, '0);
        // Removing slot 0 from the middle frees it, so the next add reuses it.
        send_op(sadll_pkg::KIND_DEL_AFTER, 4'd3, '0);
        send_op(sadll_pkg::KIND_ADD_FIRST, 4'd0, {RECORD_BITS/4{4'h9}});
        send_op(sadll_pkg::KIND_DEL_FIRST, 4'd0, '0);
        send_op(sadll_pkg::KIND_DEL_LAST, 4'd0, '0);
        send_op(sadll_pkg::KIND_DEL_AFTER, 4'd1, '0);
        send_op(sadll_pkg::KIND_DEL_LAST, 4'd0, '0);
        send_op(sadll_pkg::KIND_DEL_FIRST, 4'd0, '0);
        send_op(sadll_pkg::KIND_ADD_AFTER, 4'd15, '1);

        // Random part. The first phase always grows, so the full list and the
        // "fullness before position" case are reached early.
        sent = 0;
        ph   = PH_GROW;
        while (sent < RAND_ITEMS) begin
            phase_len   = (sent == 0) ? 40 : $urandom_range(15, 45);
            quiet_phase = ($urandom_range(0, 3) == 0);
            repeat (phase_len) begin
                kind = pick_kind(ph);
                // Positions mostly name a slot that is in the list, so the linked
                // operations get past their checks; the rest are arbitrary.
                if (shadow.count != 0 && $urandom_range(0, 9) < 8) begin
                    do pos = POS_W'($urandom_range(0, SLOTS - 1));
                    while (!shadow.used[pos]);
                end else begin
                    pos = POS_W'($urandom_range(0, SLOTS - 1));
                end
                roll = $urandom_range(0, 9);
                if (roll == 0) rec = '1;
                else if (roll == 1) rec = '0;
                else rec = {$urandom, $urandom};
                send_op(kind, pos, rec);
                sent++;
            end
            case ($urandom_range(0, 2))
                0:       ph = PH_GROW;
                1:       ph = PH_SHRINK;
                default: ph = PH_MIXED;
            endcase
        end
        i_valid     <= 1'b0;
        quiet_phase = 1'b0;

        // Drain: wait for every pending result, then keep the clock running so that any
        // stray result would still be caught by the checker.
        while (shadow.due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && shadow.due_results.size() == 0) begin
            $display("slot_array_doubly_linked_list_core_tb passed");
        end else begin
            $display("slot_array_doubly_linked_list_core_tb failed");
        end
        $finish;
    end

    // Watchdog. A run that is still going at this limit is reported as failed.
    initial begin
        #2_500_000;
        $display("slot_array_doubly_linked_list_core_tb failed");
        $finish;
    end

endmodule
